// ----- design/assert_macros.svh -----
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PIT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");
`define PIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");
`else
`define PIT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PIT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/pit_pkg.sv -----
`timescale 1ns / 1ps
package pit_pkg;

    localparam int OUT_W     = 18;
    localparam int OUT_MAX   = 131071;
    localparam int OUT_MIN   = -131072;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_A_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_C_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_C_Y = 3'd5;

    typedef struct packed {
        logic degen;
        logic in_tri;
        logic sat_b;
        logic sat_c;
        logic neg_b;
        logic neg_c;
    } pit_flags_t;

endpackage

// ----- design/pit_if.sv -----
`timescale 1ns / 1ps
interface pit_point_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] point_x;
    logic signed [W-1:0] point_y;
    modport source(output valid, point_x, point_y, input ready);
    modport sink(input valid, point_x, point_y, output ready);
endinterface

interface pit_cfg_if #(parameter int W = 16);
    import pit_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [W-1:0]         data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

interface pit_result_if;
    import pit_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    inside_res;
    logic                    degenerate;
    logic signed [OUT_W-1:0] weight_a;
    logic signed [OUT_W-1:0] weight_b;
    logic signed [OUT_W-1:0] weight_c;
    modport source(output valid, inside_res, degenerate, weight_a, weight_b, weight_c,
                   input ready);
    modport sink(input valid, inside_res, degenerate, weight_a, weight_b, weight_c,
                 output ready);
endinterface

// ----- design/pit_front.sv -----
`timescale 1ns / 1ps
module pit_front #(
    parameter int CW = 16,
    parameter int PW = 2 * CW + 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CW-1:0]         px,
    input  logic [CW-1:0]         py,
    input  logic [CW-1:0]         ax,
    input  logic [CW-1:0]         ay,
    input  logic [CW-1:0]         bx,
    input  logic [CW-1:0]         by,
    input  logic [CW-1:0]         cx,
    input  logic [CW-1:0]         cy,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PW-1:0]         d,
    output logic [PW:0]           rb,
    output logic [PW:0]           rc,
    output logic [1:0]            feed_b,
    output logic [1:0]            feed_c,
    output pit_pkg::pit_flags_t   flags
);
    import pit_pkg::*;

    localparam int DW = CW + 1;
    localparam int MW = 2 * DW;

    logic en1, en2, en3, en4, en5;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // stage 1: edge vectors
    logic signed [DW-1:0] e0x_reg, e0y_reg, e1x_reg, e1y_reg, e2x_reg, e2y_reg;
    logic signed [DW-1:0] e0x_next, e0y_next, e1x_next, e1y_next, e2x_next, e2y_next;
    // stage 2: products
    logic signed [MW-1:0] pd0_reg, pd1_reg, pb0_reg, pb1_reg, pc0_reg, pc1_reg;
    // stage 3: cross products
    logic signed [PW-1:0] den_reg, nb_reg, nc_reg;
    logic signed [PW-1:0] den_next, nb_next, nc_next;
    // stage 4: sign normalized values and magnitudes
    logic signed [PW:0] dn_reg, nbn_reg, ncn_reg;
    logic signed [PW:0] dn_next, nbn_next, ncn_next;
    logic [PW:0]        nbm_reg, ncm_reg, nbm_next, ncm_next;
    logic               negb_reg, negc_reg, degen_reg;
    // stage 5: divider setup
    logic [PW-1:0]      d_reg;
    logic [PW:0]        rb_reg, rc_reg;
    logic [1:0]         fb_reg, fc_reg;
    pit_flags_t         flags_reg, flags_next;
    logic signed [PW+2:0] na;
    logic [PW+2:0]      dx4;

    assign en5 = !v5_reg || out_ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    assign e0x_next = {bx[CW-1], bx} - {ax[CW-1], ax};
    assign e0y_next = {by[CW-1], by} - {ay[CW-1], ay};
    assign e1x_next = {cx[CW-1], cx} - {ax[CW-1], ax};
    assign e1y_next = {cy[CW-1], cy} - {ay[CW-1], ay};
    assign e2x_next = {px[CW-1], px} - {ax[CW-1], ax};
    assign e2y_next = {py[CW-1], py} - {ay[CW-1], ay};

    assign den_next = PW'(pd0_reg) - PW'(pd1_reg);
    assign nb_next  = PW'(pb0_reg) - PW'(pb1_reg);
    assign nc_next  = PW'(pc0_reg) - PW'(pc1_reg);

    always_comb
    begin
        dn_next  = den_reg[PW-1] ? -((PW+1)'(den_reg)) : (PW+1)'(den_reg);
        nbn_next = den_reg[PW-1] ? -((PW+1)'(nb_reg)) : (PW+1)'(nb_reg);
        ncn_next = den_reg[PW-1] ? -((PW+1)'(nc_reg)) : (PW+1)'(nc_reg);
        nbm_next = nb_reg[PW-1] ? -((PW+1)'(nb_reg)) : (PW+1)'(nb_reg);
        ncm_next = nc_reg[PW-1] ? -((PW+1)'(nc_reg)) : (PW+1)'(nc_reg);
    end

    assign na  = (PW+3)'(dn_reg) - (PW+3)'(nbn_reg) - (PW+3)'(ncn_reg);
    assign dx4 = {1'b0, dn_reg[PW-1:0], 2'b00};

    always_comb
    begin
        flags_next.degen  = degen_reg;
        flags_next.in_tri = (nbn_reg >= 0) && (nbn_reg <= dn_reg)
                         && (ncn_reg >= 0) && (ncn_reg <= dn_reg)
                         && (na >= 0) && (na <= (PW+3)'(dn_reg));
        flags_next.sat_b  = {2'b00, nbm_reg} >= dx4;
        flags_next.sat_c  = {2'b00, ncm_reg} >= dx4;
        flags_next.neg_b  = negb_reg;
        flags_next.neg_c  = negc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            e0x_reg <= e0x_next;
            e0y_reg <= e0y_next;
            e1x_reg <= e1x_next;
            e1y_reg <= e1y_next;
            e2x_reg <= e2x_next;
            e2y_reg <= e2y_next;
        end
        if (en2)
        begin
            pd0_reg <= e0x_reg * e1y_reg;
            pd1_reg <= e0y_reg * e1x_reg;
            pb0_reg <= e2x_reg * e1y_reg;
            pb1_reg <= e2y_reg * e1x_reg;
            pc0_reg <= e0x_reg * e2y_reg;
            pc1_reg <= e0y_reg * e2x_reg;
        end
        if (en3)
        begin
            den_reg <= den_next;
            nb_reg  <= nb_next;
            nc_reg  <= nc_next;
        end
        if (en4)
        begin
            dn_reg    <= dn_next;
            nbn_reg   <= nbn_next;
            ncn_reg   <= ncn_next;
            nbm_reg   <= nbm_next;
            ncm_reg   <= ncm_next;
            negb_reg  <= nb_reg[PW-1] ^ den_reg[PW-1];
            negc_reg  <= nc_reg[PW-1] ^ den_reg[PW-1];
            degen_reg <= (den_reg == '0);
        end
        if (en5)
        begin
            d_reg     <= dn_reg[PW-1:0];
            // integer part seeds the remainder, the two low bits are shifted in
            rb_reg    <= nbm_reg >> 2;
            rc_reg    <= ncm_reg >> 2;
            fb_reg    <= nbm_reg[1:0];
            fc_reg    <= ncm_reg[1:0];
            flags_reg <= flags_next;
        end
    end

    assign out_valid = v5_reg;
    assign d         = d_reg;
    assign rb        = rb_reg;
    assign rc        = rc_reg;
    assign feed_b    = fb_reg;
    assign feed_c    = fc_reg;
    assign flags     = flags_reg;

endmodule

// ----- design/pit_cell.sv -----
`timescale 1ns / 1ps
module pit_cell #(
    parameter int PW = 35,
    parameter int VW = 18
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [PW-1:0]       d_in,
    input  logic [PW:0]         rb_in,
    input  logic [PW:0]         rc_in,
    input  logic [VW-1:0]       qb_in,
    input  logic [VW-1:0]       qc_in,
    input  logic [1:0]          fb_in,
    input  logic [1:0]          fc_in,
    input  pit_pkg::pit_flags_t flags_in,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [PW-1:0]       d_out,
    output logic [PW:0]         rb_out,
    output logic [PW:0]         rc_out,
    output logic [VW-1:0]       qb_out,
    output logic [VW-1:0]       qc_out,
    output logic [1:0]          fb_out,
    output logic [1:0]          fc_out,
    output pit_pkg::pit_flags_t flags_out
);
    import pit_pkg::*;

    logic            en;
    logic            v_reg;
    logic [PW-1:0]   d_reg;
    logic [PW:0]     rb_reg, rc_reg, rb_next, rc_next, tb, tc;
    logic [VW-1:0]   qb_reg, qc_reg;
    logic [1:0]      fb_reg, fc_reg;
    logic            geb, gec;
    pit_flags_t      flags_reg;

    assign en       = !v_reg || out_ready;
    assign in_ready = en;

    // one restoring step per lane: shift in the next numerator bit, try subtract
    assign tb  = {rb_in[PW-1:0], fb_in[1]};
    assign tc  = {rc_in[PW-1:0], fc_in[1]};
    assign geb = tb >= {1'b0, d_in};
    assign gec = tc >= {1'b0, d_in};
    assign rb_next = geb ? tb - {1'b0, d_in} : tb;
    assign rc_next = gec ? tc - {1'b0, d_in} : tc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg     <= d_in;
            rb_reg    <= rb_next;
            rc_reg    <= rc_next;
            qb_reg    <= {qb_in[VW-2:0], geb};
            qc_reg    <= {qc_in[VW-2:0], gec};
            fb_reg    <= {fb_in[0], 1'b0};
            fc_reg    <= {fc_in[0], 1'b0};
            flags_reg <= flags_in;
        end
    end

    assign out_valid = v_reg;
    assign d_out     = d_reg;
    assign rb_out    = rb_reg;
    assign rc_out    = rc_reg;
    assign qb_out    = qb_reg;
    assign qc_out    = qc_reg;
    assign fb_out    = fb_reg;
    assign fc_out    = fc_reg;
    assign flags_out = flags_reg;

endmodule

// ----- design/point_in_triangle_barycentric.sv -----
`timescale 1ns / 1ps
// Barycentric point-in-triangle test.
// cfg: register writes (index 0..5 = A.x, A.y, B.x, B.y, C.x, C.y, signed Q12.4);
//   always ready, indexes above 5 are dropped. Write only while the block is idle.
// point: one request per point (signed Q12.4 x and y).
// result: weights a, b, c in signed Q2.16 (saturated), inside and degenerate flags.
// Throughput: one point per cycle while the receiver is ready.
// Pipeline from accept to result valid: five front stages (edges, multipliers,
//   cross products, sign fix, divider setup), one divider cell per quotient bit
//   (WEIGHT_FRAC_BITS + 2 cells, both weights in parallel), and two output stages
//   (sign and clamp, then weight a).
// Every stage holds its own valid bit and fills when empty, so a stalled receiver
// only backs up the stages behind it; new points are taken until the pipe is full.
// Reset clears all valid bits and the vertex registers to zero.
`include "assert_macros.svh"
module point_in_triangle_barycentric #(
    parameter int COORD_WIDTH      = 16,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    pit_cfg_if.sink   cfg,
    pit_point_if.sink point,
    pit_result_if.source result
);
    import pit_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int F  = WEIGHT_FRAC_BITS;
    localparam int PW = 2 * CW + 3;
    localparam int VW = F + 2;
    localparam int NC = F + 2;
    localparam int XW = (F + 4 > OUT_W + 1) ? F + 4 : OUT_W + 1;
    localparam logic [VW:0] SAT_VAL = (VW + 1)'(4) << F;

    function automatic logic [OUT_W-1:0] clamp_out(input logic signed [XW+1:0] v);
        logic [OUT_W-1:0] r;
        if (v > (XW + 2)'(OUT_MAX))
            r = OUT_W'(OUT_MAX);
        else if (v < (XW + 2)'(OUT_MIN))
            r = OUT_W'(OUT_MIN);
        else
            r = v[OUT_W-1:0];
        return r;
    endfunction

    // vertex registers
    logic [CW-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg <= '0;
            ay_reg <= '0;
            bx_reg <= '0;
            by_reg <= '0;
            cx_reg <= '0;
            cy_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_A_X: ax_reg <= cfg.data;
                REG_A_Y: ay_reg <= cfg.data;
                REG_B_X: bx_reg <= cfg.data;
                REG_B_Y: by_reg <= cfg.data;
                REG_C_X: cx_reg <= cfg.data;
                REG_C_Y: cy_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // divider chain links, element 0 comes from the front end
    logic            lv [0:NC];
    logic            lr [0:NC];
    logic [PW-1:0]   ld [0:NC];
    logic [PW:0]     lrb [0:NC];
    logic [PW:0]     lrc [0:NC];
    logic [VW-1:0]   lqb [0:NC];
    logic [VW-1:0]   lqc [0:NC];
    logic [1:0]      lfb [0:NC];
    logic [1:0]      lfc [0:NC];
    pit_flags_t      lfl [0:NC];

    pit_front #(.CW(CW), .PW(PW)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (point.valid),
        .in_ready  (point.ready),
        .px        (point.point_x),
        .py        (point.point_y),
        .ax        (ax_reg),
        .ay        (ay_reg),
        .bx        (bx_reg),
        .by        (by_reg),
        .cx        (cx_reg),
        .cy        (cy_reg),
        .out_valid (lv[0]),
        .out_ready (lr[0]),
        .d         (ld[0]),
        .rb        (lrb[0]),
        .rc        (lrc[0]),
        .feed_b    (lfb[0]),
        .feed_c    (lfc[0]),
        .flags     (lfl[0])
    );
    assign lqb[0] = '0;
    assign lqc[0] = '0;

    for (genvar k = 0; k < NC; k++)
    begin : g_cell
        pit_cell #(.PW(PW), .VW(VW)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (lv[k]),
            .in_ready  (lr[k]),
            .d_in      (ld[k]),
            .rb_in     (lrb[k]),
            .rc_in     (lrc[k]),
            .qb_in     (lqb[k]),
            .qc_in     (lqc[k]),
            .fb_in     (lfb[k]),
            .fc_in     (lfc[k]),
            .flags_in  (lfl[k]),
            .out_valid (lv[k+1]),
            .out_ready (lr[k+1]),
            .d_out     (ld[k+1]),
            .rb_out    (lrb[k+1]),
            .rc_out    (lrc[k+1]),
            .qb_out    (lqb[k+1]),
            .qc_out    (lqc[k+1]),
            .fb_out    (lfb[k+1]),
            .fc_out    (lfc[k+1]),
            .flags_out (lfl[k+1])
        );
    end

    // output stage 1: apply sign and saturate weights b and c
    logic                    en_o1, en_o2;
    logic                    o1_v_reg, o2_v_reg;
    logic signed [OUT_W-1:0] wb1_reg, wc1_reg, wb1_next, wc1_next;
    logic                    degen1_reg, inside1_reg;
    logic [VW:0]             valb, valc;
    logic signed [XW+1:0]    swb, swc, wa_sum;
    logic signed [OUT_W-1:0] wa2_reg, wb2_reg, wc2_reg, wa_next;
    logic                    degen2_reg, inside2_reg;

    assign en_o2   = !o2_v_reg || result.ready;
    assign en_o1   = !o1_v_reg || en_o2;
    assign lr[NC]  = en_o1;

    always_comb
    begin
        valb     = lfl[NC].sat_b ? SAT_VAL : {1'b0, lqb[NC]};
        valc     = lfl[NC].sat_c ? SAT_VAL : {1'b0, lqc[NC]};
        swb      = lfl[NC].neg_b ? -((XW + 2)'(valb)) : (XW + 2)'(valb);
        swc      = lfl[NC].neg_c ? -((XW + 2)'(valc)) : (XW + 2)'(valc);
        wb1_next = clamp_out(swb);
        wc1_next = clamp_out(swc);
    end

    assign wa_sum  = ((XW + 2)'(1) << F) - (XW + 2)'(wb1_reg) - (XW + 2)'(wc1_reg);
    assign wa_next = clamp_out(wa_sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o1_v_reg <= 1'b0;
            o2_v_reg <= 1'b0;
        end
        else
        begin
            if (en_o1) o1_v_reg <= lv[NC];
            if (en_o2) o2_v_reg <= o1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_o1)
        begin
            wb1_reg     <= wb1_next;
            wc1_reg     <= wc1_next;
            degen1_reg  <= lfl[NC].degen;
            inside1_reg <= lfl[NC].in_tri && !lfl[NC].degen;
        end
        if (en_o2)
        begin
            // a flat triangle reports zero weights
            wa2_reg     <= degen1_reg ? '0 : wa_next;
            wb2_reg     <= degen1_reg ? '0 : wb1_reg;
            wc2_reg     <= degen1_reg ? '0 : wc1_reg;
            degen2_reg  <= degen1_reg;
            inside2_reg <= inside1_reg;
        end
    end

    assign result.valid      = o2_v_reg;
    assign result.inside_res = inside2_reg;
    assign result.degenerate = degen2_reg;
    assign result.weight_a   = wa2_reg;
    assign result.weight_b   = wb2_reg;
    assign result.weight_c   = wc2_reg;

    `PIT_ASSERT_IMP(a_degen_zero, clk, rst_n, result.valid && result.degenerate,
        !result.inside_res && result.weight_a == '0
        && result.weight_b == '0 && result.weight_c == '0)
    `PIT_ASSERT_IMP(a_inside_nonneg, clk, rst_n, result.valid && result.inside_res,
        !result.weight_a[OUT_W-1] && !result.weight_b[OUT_W-1] && !result.weight_c[OUT_W-1])
    `PIT_ASSERT_NEXT(a_o1_hold, clk, rst_n, o1_v_reg && !en_o2,
        o1_v_reg && $stable(wb1_reg) && $stable(wc1_reg) && $stable(degen1_reg))

endmodule

// ----- sim/point_in_triangle_barycentric_tb.sv -----
`timescale 1ns / 1ps
module point_in_triangle_barycentric_tb;
    import pit_pkg::*;

    typedef struct packed {
        logic               inside_res;
        logic               degenerate;
        logic signed [17:0] weight_a;
        logic signed [17:0] weight_b;
        logic signed [17:0] weight_c;
    } bary_t;

    typedef struct {
        logic signed [15:0] px;
        logic signed [15:0] py;
        bit                 typed;
        bary_t              want;
    } point_row_t;

    localparam int  FRAC        = 16;
    localparam int  LATENCY     = 25;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  N_RANDOM    = 1300;
    localparam int  HOLD_CYCLES = 200;

    logic clk;
    logic rst_n;

    pit_cfg_if    cfg_ch();
    pit_point_if  pt_ch();
    pit_result_if res_ch();

    point_in_triangle_barycentric u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch.sink),
        .point  (pt_ch.sink),
        .result (res_ch.source)
    );

    logic signed [15:0] vert[6];
    bary_t              weights_due[$];
    int                 errors = 0;
    int                 cycles = 0;
    bit                 hold_go;
    bit                 hold_off;
    bit                 no_idle;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic longint clamp18(longint v);
        if (v > OUT_MAX) return OUT_MAX;
        if (v < OUT_MIN) return OUT_MIN;
        return v;
    endfunction

    // quotient truncated toward zero, saturated at magnitude 4
    function automatic longint weight_div(longint num, longint den);
        longint n, d, q, r, v;
        bit     neg;
        n   = (num < 0) ? -num : num;
        d   = (den < 0) ? -den : den;
        neg = (num < 0) != (den < 0);
        q   = n / d;
        r   = n % d;
        if (q >= 4) v = 64'sd4 <<< FRAC;
        else v = (q <<< FRAC) + ((r <<< FRAC) / d);
        return clamp18(neg ? -v : v);
    endfunction

    function automatic bary_t bary_weights(logic signed [15:0] px, logic signed [15:0] py);
        longint e0x, e0y, e1x, e1y, e2x, e2y, den, nb, nc, na, wa, wb, wc;
        bary_t  r;
        e0x = longint'(vert[REG_B_X]) - vert[REG_A_X];
        e0y = longint'(vert[REG_B_Y]) - vert[REG_A_Y];
        e1x = longint'(vert[REG_C_X]) - vert[REG_A_X];
        e1y = longint'(vert[REG_C_Y]) - vert[REG_A_Y];
        e2x = longint'(px) - vert[REG_A_X];
        e2y = longint'(py) - vert[REG_A_Y];
        den = e0x * e1y - e0y * e1x;
        nb  = e2x * e1y - e2y * e1x;
        nc  = e0x * e2y - e0y * e2x;
        r   = '0;
        r.degenerate = (den == 0);
        if (den != 0)
        begin
            wb = weight_div(nb, den);
            wc = weight_div(nc, den);
            wa = clamp18((64'sd1 <<< FRAC) - wb - wc);
            if (den < 0)
            begin
                den = -den;
                nb  = -nb;
                nc  = -nc;
            end
            na = den - nb - nc;
            r.inside_res = nb >= 0 && nb <= den && nc >= 0 && nc <= den
                           && na >= 0 && na <= den;
            r.weight_a = wa[17:0];
            r.weight_b = wb[17:0];
            r.weight_c = wc[17:0];
        end
        return r;
    endfunction

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 38);
    endfunction

    task automatic write_vertex(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx <= REG_C_Y) vert[idx] = value;
        @(posedge clk);
    endtask

    task automatic load_triangle(logic [15:0] ax, logic [15:0] ay, logic [15:0] bx,
                                 logic [15:0] by, logic [15:0] cx, logic [15:0] cy);
        // let the pipe drain before touching the vertices
        while (weights_due.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        write_vertex(REG_A_X, ax);
        write_vertex(REG_A_Y, ay);
        write_vertex(REG_B_X, bx);
        write_vertex(REG_B_Y, by);
        write_vertex(REG_C_X, cx);
        write_vertex(REG_C_Y, cy);
    endtask

    task automatic send_point(logic signed [15:0] px, logic signed [15:0] py);
        while (idle_now())
        begin
            pt_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pt_ch.valid   <= 1'b1;
        pt_ch.point_x <= px;
        pt_ch.point_y <= py;
        do @(posedge clk); while (!pt_ch.ready);
        weights_due.push_back(bary_weights(px, py));
    endtask

    task automatic send_typed(point_row_t row);
        send_point(row.px, row.py);
        if (row.typed) weights_due[$] = row.want;
    endtask

    task automatic send_pt_done();
        pt_ch.valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'sh7fff - 16'($urandom_range(3));
            2: return 16'sh8000 + 16'($urandom_range(3));
            default: return 16'($signed(10'($urandom)));
        endcase
    endfunction

    // long receiver hold-off, timed in cycles once started
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // receiver: random stalls, plus one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n) res_ch.ready <= 1'b0;
        else res_ch.ready <= !hold_off && !idle_now();
    end

    always @(posedge clk)
    begin
        bary_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (weights_due.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
            end
            else
            begin
                want = weights_due.pop_front();
                if (res_ch.inside_res !== want.inside_res)
                begin
                    $error("inside_res: expected %0d, got %0d", want.inside_res,
                           res_ch.inside_res);
                    errors++;
                end
                if (res_ch.degenerate !== want.degenerate)
                begin
                    $error("degenerate: expected %0d, got %0d", want.degenerate,
                           res_ch.degenerate);
                    errors++;
                end
                if (res_ch.weight_a !== want.weight_a)
                begin
                    $error("weight_a: expected %0d, got %0d", want.weight_a,
                           res_ch.weight_a);
                    errors++;
                end
                if (res_ch.weight_b !== want.weight_b)
                begin
                    $error("weight_b: expected %0d, got %0d", want.weight_b,
                           res_ch.weight_b);
                    errors++;
                end
                if (res_ch.weight_c !== want.weight_c)
                begin
                    $error("weight_c: expected %0d, got %0d", want.weight_c,
                           res_ch.weight_c);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        point_row_t rows[$];
        point_row_t row;
        int         k;
        int         wait_cycles;
        hold_go       = 1'b0;
        no_idle       = 1'b0;
        rst_n         = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
        pt_ch.valid   = 1'b0;
        pt_ch.point_x = '0;
        pt_ch.point_y = '0;
        foreach (vert[i]) vert[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset every vertex is zero: degenerate, weights zero
        row = '{16'sh0000, 16'sh0000, 1'b1, '{1'b0, 1'b1, '0, '0, '0}};
        send_typed(row);
        row = '{16'sh7fff, 16'sh8000, 1'b1, '{1'b0, 1'b1, '0, '0, '0}};
        send_typed(row);
        send_pt_done();

        // unit right triangle, 16 units per leg in Q12.4
        load_triangle(16'd0, 16'd0, 16'd256, 16'd0, 16'd0, 16'd256);
        rows = '{
            '{16'sd0,   16'sd0,   1'b1, '{1'b1, 1'b0, 18'sd65536, 18'sd0, 18'sd0}},
            '{16'sd256, 16'sd0,   1'b1, '{1'b1, 1'b0, 18'sd0, 18'sd65536, 18'sd0}},
            '{16'sd0,   16'sd256, 1'b1, '{1'b1, 1'b0, 18'sd0, 18'sd0, 18'sd65536}},
            '{16'sd128, 16'sd128, 1'b1, '{1'b1, 1'b0, 18'sd0, 18'sd32768, 18'sd32768}},
            '{16'sd129, 16'sd128, 1'b0, '0},
            '{-16'sd1,  16'sd0,   1'b0, '0},
            '{16'sh7fff, 16'sh7fff, 1'b0, '0},
            '{16'sh8000, 16'sh8000, 1'b0, '0},
            '{16'sh8000, 16'sh7fff, 1'b0, '0}
        };
        foreach (rows[i]) send_typed(rows[i]);
        send_pt_done();

        // extreme vertices, clockwise order gives a negative area
        load_triangle(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        rows = '{
            '{16'sh0000, 16'sh0000, 1'b0, '0},
            '{16'sh8000, 16'sh8000, 1'b0, '0},
            '{16'sh7fff, 16'sh7fff, 1'b0, '0},
            '{16'sh1234, 16'shedcb, 1'b0, '0}
        };
        foreach (rows[i]) send_typed(rows[i]);
        send_pt_done();

        // collinear vertices and a write to an unused index
        load_triangle(16'd16, 16'd16, 16'd32, 16'd32, 16'd64, 16'd64);
        write_vertex(3'd6, 16'h5555);
        write_vertex(3'd7, 16'haaaa);
        row = '{16'sd5, 16'sd9, 1'b1, '{1'b0, 1'b1, '0, '0, '0}};
        send_typed(row);
        send_pt_done();

        // tiny triangle: far points saturate the weights
        load_triangle(16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1);
        rows = '{
            '{16'sh7fff, 16'sh0000, 1'b0, '0},
            '{16'sh8000, 16'sh8000, 1'b0, '0},
            '{16'sh0001, 16'sh0001, 1'b0, '0}
        };
        foreach (rows[i]) send_typed(rows[i]);

        for (k = 0; k < N_RANDOM; k++)
        begin
            if (k % 100 == 0)
            begin
                send_pt_done();
                if ($urandom_range(3) == 0)
                    load_triangle(16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom), 16'($urandom));
                else
                    load_triangle(rand_coord(), rand_coord(), rand_coord(),
                                  rand_coord(), rand_coord(), rand_coord());
            end
            no_idle  = (k >= 400 && k < 550);
            // long receiver hold-off while points keep coming
            if (k == 700) hold_go = 1'b1;
            // bias toward points near the triangle so both flag values show up
            if ($urandom_range(1))
                send_point(16'(vert[$urandom_range(5) & 3'b110] + $signed(8'($urandom))),
                           16'(vert[($urandom_range(5) & 3'b110) | 1] + $signed(8'($urandom))));
            else
                send_point(rand_coord(), rand_coord());
        end
        send_pt_done();
        no_idle  = 1'b0;

        wait_cycles = 0;
        while (weights_due.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LATENCY + 4) @(posedge clk);
        if (errors == 0 && weights_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/pit_pkg.sv
design/pit_if.sv
design/pit_front.sv
design/pit_cell.sv
design/point_in_triangle_barycentric.sv
sim/point_in_triangle_barycentric_tb.sv
